@@ sv/crrt_pkg.sv @@
// Shared definitions for the client rate request table.
// Command codes, field widths and the default slot count; no dependencies.
package crrt_pkg;

   localparam int CRRT_ENTRIES = 16;

   localparam int CMD_W      = 2;
   localparam int CLIENT_W   = 16;
   localparam int INTERVAL_W = 32;
   localparam int LATENCY_W  = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

endpackage

@@ sv/client_rate_request_table_core.sv @@
// Client rate request table: slot memory, valid bits and the scan sequencer.
// Depends on crrt_pkg for command codes and field widths.

// A transaction is taken on start while busy is low and answers with one
// result, shown for a single cycle with rsp_valid high; the receiver cannot
// stall it, so it must take every result. Busy stays high from the accepting
// edge until the transaction is done: the slot memory has one read port with a
// registered read, so the sequencer first reads slot 0, then compares one slot
// per cycle for match, first free slot and both minima, then writes back and
// registers the result in the finish state. The result is shown in the first
// cycle with busy low. Valid bits clear at reset.
module client_rate_request_table_core
   import crrt_pkg::*;
#(
   parameter int ENTRIES = CRRT_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [CLIENT_W-1:0]   req_client_id,
   input  logic [INTERVAL_W-1:0] req_interval,
   input  logic [LATENCY_W-1:0]  req_latency,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic [INTERVAL_W-1:0] rsp_found_interval,
   output logic [LATENCY_W-1:0]  rsp_found_latency,
   output logic                  rsp_any_active,
   output logic [INTERVAL_W-1:0] rsp_min_interval,
   output logic [LATENCY_W-1:0]  rsp_min_latency
);

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SLOT_W  = CLIENT_W + INTERVAL_W + LATENCY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Slot memory: {client, interval, latency}
   logic [SLOT_W-1:0] slot_mem [ENTRIES];
   logic [SLOT_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  wr_idx;

   state_type               state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [CLIENT_W-1:0]     id_ff, id_in;
   logic [INTERVAL_W-1:0]   ivl_ff, ivl_in;
   logic [LATENCY_W-1:0]    lat_ff, lat_in;

   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rd_on_ff, rd_on_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                    cmp_on_ff, cmp_on_in;

   logic                    match_ff, match_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic [INTERVAL_W-1:0]   match_ivl_ff, match_ivl_in;
   logic [LATENCY_W-1:0]    match_lat_ff, match_lat_in;
   logic                    free_ff, free_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    oth_any_ff, oth_any_in;
   logic [INTERVAL_W-1:0]   oth_ivl_ff, oth_ivl_in;
   logic [LATENCY_W-1:0]    oth_lat_ff, oth_lat_in;

   logic [ENTRIES-1:0]      slot_valid_ff, slot_valid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    ok_ff, ok_in;
   logic [INTERVAL_W-1:0]   f_ivl_ff, f_ivl_in;
   logic [LATENCY_W-1:0]    f_lat_ff, f_lat_in;
   logic                    any_ff, any_in;
   logic [INTERVAL_W-1:0]   m_ivl_ff, m_ivl_in;
   logic [LATENCY_W-1:0]    m_lat_ff, m_lat_in;

   // Fields of the slot under compare
   logic [CLIENT_W-1:0]     rd_client;
   logic [INTERVAL_W-1:0]   rd_ivl;
   logic [LATENCY_W-1:0]    rd_lat;
   logic                    rd_valid;

   // Finish-cycle terms
   logic                    is_add, is_remove, is_lookup;
   logic                    stored;
   logic                    cand_on;
   logic [INTERVAL_W-1:0]   cand_ivl;
   logic [LATENCY_W-1:0]    cand_lat;

   assign rd_client = rd_data_ff[SLOT_W-1 -: CLIENT_W];
   assign rd_ivl    = rd_data_ff[INTERVAL_W+LATENCY_W-1 -: INTERVAL_W];
   assign rd_lat    = rd_data_ff[LATENCY_W-1:0];
   assign rd_valid  = slot_valid_ff[cmp_idx_ff];

   assign is_add    = (cmd_ff == CMD_ADD);
   assign is_remove = (cmd_ff == CMD_REMOVE);
   assign is_lookup = (cmd_ff == CMD_LOOKUP);
   assign stored    = is_add && (match_ff || free_ff);
   assign wr_idx    = match_ff ? match_idx_ff : free_idx_ff;

   // The one slot kept out of the running minima joins back here: with the
   // new values after a store, unchanged unless removed otherwise.
   always_comb begin
      cand_on  = 1'b0;
      cand_ivl = match_ivl_ff;
      cand_lat = match_lat_ff;
      if (stored) begin
         cand_on  = 1'b1;
         cand_ivl = ivl_ff;
         cand_lat = lat_ff;
      end else if (match_ff && !is_add && !is_remove) begin
         cand_on = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      ivl_in        = ivl_ff;
      lat_in        = lat_ff;
      rd_idx_in     = rd_idx_ff;
      rd_on_in      = rd_on_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_on_in     = cmp_on_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_ivl_in  = match_ivl_ff;
      match_lat_in  = match_lat_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      oth_any_in    = oth_any_ff;
      oth_ivl_in    = oth_ivl_ff;
      oth_lat_in    = oth_lat_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = 1'b0;
      ok_in         = ok_ff;
      f_ivl_in      = f_ivl_ff;
      f_lat_in      = f_lat_ff;
      any_in        = any_ff;
      m_ivl_in      = m_ivl_ff;
      m_lat_in      = m_lat_ff;
      mem_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               id_in      = req_client_id;
               ivl_in     = req_interval;
               lat_in     = req_latency;
               rd_idx_in  = '0;
               rd_on_in   = 1'b1;
               cmp_on_in  = 1'b0;
               match_in   = 1'b0;
               free_in    = 1'b0;
               oth_any_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Advance the read address; the compare stage follows it in the next cycle
            cmp_on_in  = rd_on_ff;
            cmp_idx_in = rd_idx_ff;
            if (rd_on_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  rd_on_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (cmp_on_ff) begin
               if (rd_valid && rd_client == id_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = cmp_idx_ff;
                  match_ivl_in = rd_ivl;
                  match_lat_in = rd_lat;
               end else if (rd_valid) begin
                  oth_any_in = 1'b1;
                  if (!oth_any_ff || rd_ivl < oth_ivl_ff) begin
                     oth_ivl_in = rd_ivl;
                  end
                  if (!oth_any_ff || rd_lat < oth_lat_ff) begin
                     oth_lat_in = rd_lat;
                  end
               end else if (!free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (stored) begin
               mem_we                = 1'b1;
               slot_valid_in[wr_idx] = 1'b1;
            end
            if (is_remove && match_ff) begin
               slot_valid_in[match_idx_ff] = 1'b0;
            end
            ok_in    = stored || ((is_remove || is_lookup) && match_ff);
            f_ivl_in = (is_lookup && match_ff) ? match_ivl_ff : '0;
            f_lat_in = (is_lookup && match_ff) ? match_lat_ff : '0;
            any_in   = oth_any_ff || cand_on;
            m_ivl_in = '0;
            m_lat_in = '0;
            if (oth_any_ff) begin
               m_ivl_in = oth_ivl_ff;
               m_lat_in = oth_lat_ff;
            end
            if (cand_on && (!oth_any_ff || cand_ivl < oth_ivl_ff)) begin
               m_ivl_in = cand_ivl;
            end
            if (cand_on && (!oth_any_ff || cand_lat < oth_lat_ff)) begin
               m_lat_in = cand_lat;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_on_ff      <= 1'b0;
         cmp_on_ff     <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_on_ff      <= rd_on_in;
         cmp_on_ff     <= cmp_on_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      ivl_ff       <= ivl_in;
      lat_ff       <= lat_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_ivl_ff <= match_ivl_in;
      match_lat_ff <= match_lat_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      oth_any_ff   <= oth_any_in;
      oth_ivl_ff   <= oth_ivl_in;
      oth_lat_ff   <= oth_lat_in;
      ok_ff        <= ok_in;
      f_ivl_ff     <= f_ivl_in;
      f_lat_ff     <= f_lat_in;
      any_ff       <= any_in;
      m_ivl_ff     <= m_ivl_in;
      m_lat_ff     <= m_lat_in;
   end

   // Reads happen only while scanning and writes only in the finish cycle,
   // so the port never sees a read and write to the same slot together.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_idx] <= {id_ff, ivl_ff, lat_ff};
      end
      if (rd_on_ff) begin
         rd_data_ff <= slot_mem[rd_idx_ff];
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_found_interval = f_ivl_ff;
   assign rsp_found_latency  = f_lat_ff;
   assign rsp_any_active     = any_ff;
   assign rsp_min_interval   = m_ivl_ff;
   assign rsp_min_latency    = m_lat_ff;

endmodule

@@ test/crrt_answer_checker.sv @@
`timescale 1ns / 1ps
// Answer checker for the client rate request table: keeps its own copy of the
// slot table, predicts every answer and compares it field by field. Uses crrt_pkg.
module crrt_answer_checker
   import crrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [CLIENT_W-1:0]   req_client_id,
   input  logic [INTERVAL_W-1:0] req_interval,
   input  logic [LATENCY_W-1:0]  req_latency,
   input  logic                  rsp_valid,
   input  logic                  rsp_ok,
   input  logic [INTERVAL_W-1:0] rsp_found_interval,
   input  logic [LATENCY_W-1:0]  rsp_found_latency,
   input  logic                  rsp_any_active,
   input  logic [INTERVAL_W-1:0] rsp_min_interval,
   input  logic [LATENCY_W-1:0]  rsp_min_latency,
   output int                    mismatches,
   output int                    outstanding,
   output int                    answers_checked,
   output int                    full_rejects
);

   typedef struct packed {
      logic                  ok;
      logic [INTERVAL_W-1:0] found_interval;
      logic [LATENCY_W-1:0]  found_latency;
      logic                  any_active;
      logic [INTERVAL_W-1:0] min_interval;
      logic [LATENCY_W-1:0]  min_latency;
   } answer_type;

   logic                  held          [CRRT_ENTRIES];
   logic [CLIENT_W-1:0]   held_client   [CRRT_ENTRIES];
   logic [INTERVAL_W-1:0] held_interval [CRRT_ENTRIES];
   logic [LATENCY_W-1:0]  held_latency  [CRRT_ENTRIES];

   answer_type answer_q [$];

   // Apply one request to the mirrored table and return the answer it earns.
   function automatic answer_type apply_request(input logic [CMD_W-1:0]      cmd,
                                                input logic [CLIENT_W-1:0]   id,
                                                input logic [INTERVAL_W-1:0] ivl,
                                                input logic [LATENCY_W-1:0]  lat);
      answer_type a;
      int         hit;
      int         spot;
      a    = '0;
      hit  = -1;
      spot = -1;
      for (int i = 0; i < CRRT_ENTRIES; i++) begin
         if (held[i] && held_client[i] == id && hit < 0)
            hit = i;
         if (!held[i] && spot < 0)
            spot = i;
      end
      case (cmd)
         CMD_ADD: begin
            // update in place, else take the lowest free slot
            if (hit < 0)
               hit = spot;
            if (hit >= 0) begin
               held[hit]          = 1'b1;
               held_client[hit]   = id;
               held_interval[hit] = ivl;
               held_latency[hit]  = lat;
               a.ok               = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit >= 0) begin
               held[hit] = 1'b0;
               a.ok      = 1'b1;
            end
         end
         CMD_LOOKUP: begin
            if (hit >= 0) begin
               a.ok             = 1'b1;
               a.found_interval = held_interval[hit];
               a.found_latency  = held_latency[hit];
            end
         end
         default: ;
      endcase
      // the two minima are independent of each other
      for (int i = 0; i < CRRT_ENTRIES; i++) begin
         if (held[i]) begin
            if (!a.any_active || held_interval[i] < a.min_interval)
               a.min_interval = held_interval[i];
            if (!a.any_active || held_latency[i] < a.min_latency)
               a.min_latency = held_latency[i];
            a.any_active = 1'b1;
         end
      end
      return a;
   endfunction

   initial begin
      mismatches      = 0;
      outstanding     = 0;
      answers_checked = 0;
      full_rejects    = 0;
   end

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         for (int i = 0; i < CRRT_ENTRIES; i++)
            held[i] = 1'b0;
         answer_q.delete();
         outstanding = 0;
      end else begin
         // check the answer before queuing a transaction taken at the same edge
         if (rsp_valid) begin
            got = {rsp_ok, rsp_found_interval, rsp_found_latency,
                   rsp_any_active, rsp_min_interval, rsp_min_latency};
            if (answer_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: stray answer ok=%0b found=%h/%h any=%0b min=%h/%h",
                           got.ok, got.found_interval, got.found_latency,
                           got.any_active, got.min_interval, got.min_latency);
            end else begin
               want = answer_q.pop_front();
               answers_checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch on answer %0d:", answers_checked);
                     $display("  expected ok=%0b found=%h/%h any=%0b min=%h/%h",
                              want.ok, want.found_interval,
                              want.found_latency, want.any_active,
                              want.min_interval, want.min_latency);
                     $display("  actual   ok=%0b found=%h/%h any=%0b min=%h/%h",
                              got.ok, got.found_interval, got.found_latency,
                              got.any_active, got.min_interval, got.min_latency);
                  end
               end
            end
         end
         if (start && !busy) begin
            want = apply_request(req_command, req_client_id, req_interval, req_latency);
            if (req_command == CMD_ADD && !want.ok)
               full_rejects++;
            answer_q.push_back(want);
         end
         outstanding = answer_q.size();
      end
   end

endmodule

@@ test/client_rate_request_table_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for client_rate_request_table_core: drives directed and random
// transactions and gives the verdict. Needs crrt_pkg and crrt_answer_checker.
module client_rate_request_table_core_tb;
   import crrt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1200;
   localparam int BLOCK_ITEMS    = 60;
   localparam int POOL_SIZE      = 20;
   localparam int DRAIN_CYCLES   = CRRT_ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 200;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_command;
   logic [CLIENT_W-1:0]   req_client_id;
   logic [INTERVAL_W-1:0] req_interval;
   logic [LATENCY_W-1:0]  req_latency;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [INTERVAL_W-1:0] rsp_found_interval;
   logic [LATENCY_W-1:0]  rsp_found_latency;
   logic                  rsp_any_active;
   logic [INTERVAL_W-1:0] rsp_min_interval;
   logic [LATENCY_W-1:0]  rsp_min_latency;

   int mismatches;
   int outstanding;
   int answers_checked;
   int full_rejects;

   int idle_cycles = 0;
   int cmd_count [4] = '{default: 0};
   bit no_gaps = 1'b0;
   logic [CLIENT_W-1:0] id_pool [POOL_SIZE];

   client_rate_request_table_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_client_id      (req_client_id),
      .req_interval       (req_interval),
      .req_latency        (req_latency),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_found_interval (rsp_found_interval),
      .rsp_found_latency  (rsp_found_latency),
      .rsp_any_active     (rsp_any_active),
      .rsp_min_interval   (rsp_min_interval),
      .rsp_min_latency    (rsp_min_latency)
   );

   crrt_answer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_client_id      (req_client_id),
      .req_interval       (req_interval),
      .req_latency        (req_latency),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_found_interval (rsp_found_interval),
      .rsp_found_latency  (rsp_found_latency),
      .rsp_any_active     (rsp_any_active),
      .rsp_min_interval   (rsp_min_interval),
      .rsp_min_latency    (rsp_min_latency),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .answers_checked    (answers_checked),
      .full_rejects       (full_rejects)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: %0d cycles without a transaction or answer", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Half the time zero, all-ones or a small value, so the minima and bounds get hit.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return 32'($urandom_range(0, 255));
         default: return 32'($urandom);
      endcase
   endfunction

   // Present one transaction from a falling edge and hold it until taken.
   task automatic send(input logic [CMD_W-1:0]      cmd,
                       input logic [CLIENT_W-1:0]   id,
                       input logic [INTERVAL_W-1:0] ivl,
                       input logic [LATENCY_W-1:0]  lat);
      int gap;
      bit took;
      gap  = no_gaps ? 0 : $urandom_range(0, 4);
      took = 1'b0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_command   <= cmd;
      req_client_id <= id;
      req_interval  <= ivl;
      req_latency   <= lat;
      // busy only moves at the rising edge, so its value here holds for that edge
      while (!took) begin
         took = !busy;
         @(negedge clock);
      end
      cmd_count[cmd]++;
   endtask

   initial begin
      int                  mode;
      int                  add_pct;
      int                  remove_pct;
      int                  roll;
      logic [CMD_W-1:0]    cmd;
      logic [CLIENT_W-1:0] id;
      reset         = 1'b1;
      start         = 1'b0;
      req_command   = CMD_ADD;
      req_client_id = '0;
      req_interval  = '0;
      req_latency   = '0;
      id_pool[0]    = '0;
      id_pool[1]    = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         id_pool[i] = CLIENT_W'($urandom);
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, update, absent ids, unused code
      send(CMD_LOOKUP, 16'h0000, '1, '1);
      send(CMD_REMOVE, 16'h0005, '0, '0);
      send(CMD_UNUSED, 16'h0000, '1, '1);
      send(CMD_ADD,    16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send(CMD_ADD,    16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send(CMD_LOOKUP, 16'hFFFF, '0, '0);
      send(CMD_ADD,    16'h0000, 32'h0000_0001, 32'h0000_0001);
      send(CMD_LOOKUP, 16'h0000, '0, '0);
      send(CMD_UNUSED, 16'h0000, pick_word(), pick_word());
      send(CMD_REMOVE, 16'hFFFF, '0, '0);
      send(CMD_REMOVE, 16'hFFFF, '0, '0);
      send(CMD_LOOKUP, 16'hFFFF, '0, '0);
      send(CMD_REMOVE, 16'h0000, '0, '0);
      send(CMD_ADD,    16'h1234, 32'hAAAA_AAAA, 32'h5555_5555);
      send(CMD_ADD,    16'hEDCB, 32'h5555_5555, 32'hAAAA_AAAA);
      send(CMD_LOOKUP, 16'hEDCB, '0, '0);
      send(CMD_LOOKUP, 16'h1234, '0, '0);

      // random: blocks that lean toward filling, draining or a mix
      for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
         mode       = $urandom_range(0, 2);
         add_pct    = (mode == 0) ? 70 : (mode == 1) ? 20 : 40;
         remove_pct = (mode == 0) ? 10 : (mode == 1) ? 55 : 25;
         no_gaps    = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               cmd = CMD_UNUSED;
            else if (roll < 3 + add_pct)
               cmd = CMD_ADD;
            else if (roll < 3 + add_pct + remove_pct)
               cmd = CMD_REMOVE;
            else
               cmd = CMD_LOOKUP;
            if ($urandom_range(0, 9) == 0)
               id = CLIENT_W'($urandom);
            else
               id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            send(cmd, id, pick_word(), pick_word());
         end
      end

      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      // catch any stray answer after the last expected one
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d transactions: %0d add, %0d remove, %0d lookup, %0d unused code",
               cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
               cmd_count[CMD_ADD], cmd_count[CMD_REMOVE], cmd_count[CMD_LOOKUP],
               cmd_count[CMD_UNUSED]);
      $display("%0d answers compared, %0d adds refused by a full table, %0d mismatches",
               answers_checked, full_rejects, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
